>>> hw/rtl/dcfir_pkg.sv
// Shared types and constants of the decimating complex FIR.
package dcfir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TAP_IDX_W  = 6;
    localparam int FACTOR_W   = 9;
    localparam int PHASE_W    = 8;
    localparam int FACTOR_MAX = 256;
    localparam int ROUND_BIAS = 16384;
    localparam int FRAC_BITS  = 15;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TAP    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clr_we;    // zero both stores at the sweep counter
        logic smp_we;    // write the accepted sample into the history
        logic tap_we;    // write the accepted tap
        logic rd_en;     // issue one tap read pair
        logic first;     // first tap of a run, restarts the accumulator
        logic load_out;  // round, saturate and load the output register
    } t_fir_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;      // multiply-accumulate pipeline still holds terms
    } t_fir_sts;

endpackage

>>> hw/rtl/dcfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/dcfir_ctrl.sv
// Controller: clearing sweep, decimation phase, tap sequencing and output handshake.
module dcfir_ctrl #(
    parameter int TAPS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dcfir_pkg::FACTOR_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_req_type,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  dcfir_pkg::t_fir_sts          i_sts,
    output dcfir_pkg::t_fir_cmd          o_cmd,
    output logic [$clog2(TAPS)-1:0]      o_wslot,
    output logic [$clog2(TAPS)-1:0]      o_cnt,
    output logic [$clog2(TAPS)-1:0]      o_rptr
);
    import dcfir_pkg::*;

    localparam int AW = $clog2(TAPS);
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_DONE} t_state;

    t_state               r_state;
    logic [FACTOR_W-1:0]  r_factor;
    logic [PHASE_W-1:0]   r_phase;
    logic [AW-1:0]        r_slot;
    logic [AW-1:0]        r_cnt;
    logic [AW-1:0]        r_rptr;
    logic                 r_out_valid;

    logic                 accept;
    logic                 smp_acc;
    logic [FACTOR_W-1:0]  fac_eff;
    logic [FACTOR_W-1:0]  n_phase;
    logic [AW-1:0]        n_slot;
    logic                 fire;

    assign accept  = i_in_valid && o_in_ready;
    assign smp_acc = accept && (i_req_type == REQ_SAMPLE);

    always_comb begin
        if (r_factor == '0) begin
            fac_eff = FACTOR_W'(1);
        end else if (r_factor > FACTOR_W'(FACTOR_MAX)) begin
            fac_eff = FACTOR_W'(FACTOR_MAX);
        end else begin
            fac_eff = r_factor;
        end
    end

    assign n_phase = FACTOR_W'(r_phase) + FACTOR_W'(1);
    assign n_slot  = (r_slot == LAST) ? '0 : r_slot + AW'(1);
    assign fire    = (r_state == ST_DONE) && !i_sts.busy && (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_wslot     = r_slot;
    assign o_cnt       = r_cnt;
    assign o_rptr      = r_rptr;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_we   = (r_state == ST_CLEAR);
        o_cmd.smp_we   = smp_acc;
        o_cmd.tap_we   = accept && (i_req_type == REQ_TAP);
        o_cmd.rd_en    = (r_state == ST_RUN);
        o_cmd.first    = (r_state == ST_RUN) && (r_cnt == '0);
        o_cmd.load_out = fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_factor    <= FACTOR_W'(1);
            r_phase     <= '0;
            r_slot      <= '0;
            r_cnt       <= '0;
            r_rptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_factor <= i_cfg_data;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + AW'(1);
                    if (r_cnt == LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (smp_acc) begin
                        r_slot <= n_slot;
                        if (n_phase < fac_eff) begin
                            r_phase <= n_phase[PHASE_W-1:0];
                        end else begin
                            r_phase <= '0;
                            r_cnt   <= '0;
                            r_rptr  <= r_slot;
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_cnt  <= (r_cnt == LAST) ? '0 : r_cnt + AW'(1);
                    r_rptr <= (r_rptr == '0) ? LAST : r_rptr - AW'(1);
                    if (r_cnt == LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/dcfir_dp.sv
// Datapath: sample history and tap stores, complex MAC pipeline, rounding and output register.
module dcfir_dp #(
    parameter int TAPS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dcfir_pkg::t_fir_cmd                    i_cmd,
    output dcfir_pkg::t_fir_sts                    o_sts,
    input  logic [$clog2(TAPS)-1:0]                i_wslot,
    input  logic [$clog2(TAPS)-1:0]                i_cnt,
    input  logic [$clog2(TAPS)-1:0]                i_rptr,
    input  logic signed [dcfir_pkg::SAMPLE_W-1:0]  i_sample_re,
    input  logic signed [dcfir_pkg::SAMPLE_W-1:0]  i_sample_im,
    input  logic [dcfir_pkg::TAP_IDX_W-1:0]        i_tap_index,
    input  logic signed [dcfir_pkg::SAMPLE_W-1:0]  i_tap_re,
    input  logic signed [dcfir_pkg::SAMPLE_W-1:0]  i_tap_im,
    output logic signed [dcfir_pkg::SAMPLE_W-1:0]  o_out_re,
    output logic signed [dcfir_pkg::SAMPLE_W-1:0]  o_out_im,
    output logic                                   o_clipped
);
    import dcfir_pkg::*;

    localparam int AW    = $clog2(TAPS);
    localparam int EW    = AW + TAP_IDX_W;
    localparam int PW    = 2 * SAMPLE_W;
    localparam int SW    = PW + 1;
    localparam int ACC_W = SW + AW + 1;
    localparam int CW    = 2 * SAMPLE_W;

    logic            smp_we;
    logic [AW-1:0]   smp_waddr;
    logic [CW-1:0]   smp_wdata;
    logic [CW-1:0]   smp_rdata;
    logic            tap_we;
    logic [AW-1:0]   tap_waddr;
    logic [CW-1:0]   tap_wdata;
    logic [CW-1:0]   tap_rdata;
    logic [EW-1:0]   tap_idx_ext;

    logic                    r_v1, r_v2, r_v3;
    logic                    r_f1, r_f2, r_f3;
    logic signed [PW-1:0]    r_rr, r_ii, r_ri, r_ir;
    logic signed [SW-1:0]    r_sre, r_sim;
    logic signed [ACC_W-1:0] r_acc_re, r_acc_im;
    logic signed [SAMPLE_W-1:0] r_out_re, r_out_im;
    logic                    r_clipped;

    logic signed [SAMPLE_W-1:0] xr, xi, hr, hi;
    logic [SAMPLE_W:0]          sat_re, sat_im;

    assign tap_idx_ext = EW'(i_tap_index);

    assign smp_we    = i_cmd.clr_we || i_cmd.smp_we;
    assign smp_waddr = i_cmd.clr_we ? i_cnt : i_wslot;
    assign smp_wdata = i_cmd.clr_we ? '0 : {i_sample_im, i_sample_re};

    assign tap_we    = i_cmd.clr_we || (i_cmd.tap_we && (tap_idx_ext < EW'(TAPS)));
    assign tap_waddr = i_cmd.clr_we ? i_cnt : tap_idx_ext[AW-1:0];
    assign tap_wdata = i_cmd.clr_we ? '0 : {i_tap_im, i_tap_re};

    dcfir_ram #(.WIDTH(CW), .DEPTH(TAPS)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (smp_waddr),
        .i_wdata (smp_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rptr),
        .o_rdata (smp_rdata)
    );

    dcfir_ram #(.WIDTH(CW), .DEPTH(TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (tap_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cnt),
        .o_rdata (tap_rdata)
    );

    assign xr = $signed(smp_rdata[SAMPLE_W-1:0]);
    assign xi = $signed(smp_rdata[CW-1:SAMPLE_W]);
    assign hr = $signed(tap_rdata[SAMPLE_W-1:0]);
    assign hi = $signed(tap_rdata[CW-1:SAMPLE_W]);

    // round half up, floor shift, saturate; result is {clip, value}
    function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] q;
        v = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W+1)'(ROUND_BIAS));
        q = v >>> FRAC_BITS;
        if (q > $signed((ACC_W+1)'(32767))) begin
            round_sat = {1'b1, 1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (q < -$signed((ACC_W+1)'(32768))) begin
            round_sat = {1'b1, 1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            round_sat = {1'b0, q[SAMPLE_W-1:0]};
        end
    endfunction

    assign sat_re = round_sat(r_acc_re);
    assign sat_im = round_sat(r_acc_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= i_cmd.first;
        r_f2 <= r_f1;
        r_f3 <= r_f2;
        r_rr <= xr * hr;
        r_ii <= xi * hi;
        r_ri <= xr * hi;
        r_ir <= xi * hr;
        r_sre <= SW'(r_rr) - SW'(r_ii);
        r_sim <= SW'(r_ri) + SW'(r_ir);
        if (r_v3) begin
            r_acc_re <= (r_f3 ? '0 : r_acc_re) + ACC_W'(r_sre);
            r_acc_im <= (r_f3 ? '0 : r_acc_im) + ACC_W'(r_sim);
        end
        if (i_cmd.load_out) begin
            r_out_re  <= $signed(sat_re[SAMPLE_W-1:0]);
            r_out_im  <= $signed(sat_im[SAMPLE_W-1:0]);
            r_clipped <= sat_re[SAMPLE_W] || sat_im[SAMPLE_W];
        end
    end

    assign o_sts.busy = r_v1 || r_v2 || r_v3;
    assign o_out_re   = r_out_re;
    assign o_out_im   = r_out_im;
    assign o_clipped  = r_clipped;
endmodule

>>> hw/rtl/decimating_complex_fir.sv
// Top level of the decimating complex FIR filter.
// A sample item that does not complete a decimation period and a tap-write item each leave
// the block ready for the next item. A sample item that completes the period starts one
// complex multiply-accumulate per tap and cycle through the history and tap RAMs before
// its result is loaded into the output register; the next item is accepted while that
// result waits. After reset a clearing pass zeroes both RAMs; no item is accepted during
// it, configuration writes are.
module decimating_complex_fir #(
    parameter int TAPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,      // decimation_factor
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_re[15:0], sample_im[31:16], tap_index[37:32], tap_re[53:38], tap_im[69:54]
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tuser,    // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // out_re[15:0], out_im[31:16]
    output logic        m_axis_tuser     // clipped
);
    import dcfir_pkg::*;

    localparam int AW = $clog2(TAPS);

    t_fir_cmd      cmd;
    t_fir_sts      sts;
    logic [AW-1:0] wslot;
    logic [AW-1:0] cnt;
    logic [AW-1:0] rptr;
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;

    dcfir_ctrl #(.TAPS(TAPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_wslot     (wslot),
        .o_cnt       (cnt),
        .o_rptr      (rptr)
    );

    dcfir_dp #(.TAPS(TAPS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_wslot     (wslot),
        .i_cnt       (cnt),
        .i_rptr      (rptr),
        .i_sample_re ($signed(s_axis_tdata[15:0])),
        .i_sample_im ($signed(s_axis_tdata[31:16])),
        .i_tap_index (s_axis_tdata[37:32]),
        .i_tap_re    ($signed(s_axis_tdata[53:38])),
        .i_tap_im    ($signed(s_axis_tdata[69:54])),
        .o_out_re    (out_re),
        .o_out_im    (out_im),
        .o_clipped   (m_axis_tuser)
    );

    assign m_axis_tdata = {out_im, out_re};
endmodule

>>> verif/dcfir_checker.sv
// Stream monitor, output predictor and comparator for the decimating complex FIR.
`timescale 1ns / 1ps

module dcfir_checker #(
    parameter int TAPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic        i_in_kind,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_clip,
    output int          o_pending,
    output int          o_errors
);
    import dcfir_pkg::*;

    localparam longint PART_MAX = 32767;
    localparam longint PART_MIN = -32768;

    typedef struct packed {
        logic                clip;
        logic [SAMPLE_W-1:0] im;
        logic [SAMPLE_W-1:0] re;
    } t_fir_result;

    logic signed [SAMPLE_W-1:0] hist_re [TAPS];
    logic signed [SAMPLE_W-1:0] hist_im [TAPS];
    logic signed [SAMPLE_W-1:0] coef_re [TAPS];
    logic signed [SAMPLE_W-1:0] coef_im [TAPS];
    int                         slot;
    logic [PHASE_W-1:0]         phase;
    logic [FACTOR_W-1:0]        factor;

    t_fir_result pending_outputs[$];
    t_fir_result want;
    int          mismatches = 0;

    task automatic log_mismatch(input string what, input int got, input int exp_val);
        $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    function automatic logic [SAMPLE_W-1:0] scale_part(input longint acc, inout logic clip);
        longint q;
        q = (acc + ROUND_BIAS) >>> FRAC_BITS;
        if (q > PART_MAX) begin
            clip = 1'b1;
            q = PART_MAX;
        end else if (q < PART_MIN) begin
            clip = 1'b1;
            q = PART_MIN;
        end
        scale_part = q[SAMPLE_W-1:0];
    endfunction

    // tap i times the sample i steps older than the newest
    function automatic t_fir_result filter_output();
        longint      acc_re;
        longint      acc_im;
        int          idx;
        t_fir_result r;
        logic        clip;
        acc_re = 0;
        acc_im = 0;
        clip   = 1'b0;
        for (int i = 0; i < TAPS; i++) begin
            idx = (slot + TAPS - i) % TAPS;
            acc_re += longint'(hist_re[idx]) * longint'(coef_re[i])
                    - longint'(hist_im[idx]) * longint'(coef_im[i]);
            acc_im += longint'(hist_re[idx]) * longint'(coef_im[i])
                    + longint'(hist_im[idx]) * longint'(coef_re[i]);
        end
        r.re   = scale_part(acc_re, clip);
        r.im   = scale_part(acc_im, clip);
        r.clip = clip;
        filter_output = r;
    endfunction

    task automatic take_item(input logic kind, input logic [71:0] data);
        int                  tidx;
        logic [FACTOR_W-1:0] period;
        logic [FACTOR_W-1:0] next;
        if (kind == REQ_TAP) begin
            tidx = int'(data[37:32]);
            if (tidx < TAPS) begin
                coef_re[tidx] = data[53:38];
                coef_im[tidx] = data[69:54];
            end
        end else begin
            hist_re[slot] = data[15:0];
            hist_im[slot] = data[31:16];
            if (factor == 0)
                period = FACTOR_W'(1);
            else if (factor > FACTOR_MAX)
                period = FACTOR_W'(FACTOR_MAX);
            else
                period = factor;
            next = {1'b0, phase} + 1'b1;
            if (next < period) begin
                phase = next[PHASE_W-1:0];
            end else begin
                phase = '0;
                pending_outputs.push_back(filter_output());
            end
            slot = (slot + 1) % TAPS;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                hist_re[k] = '0;
                hist_im[k] = '0;
                coef_re[k] = '0;
                coef_im[k] = '0;
            end
            slot   = 0;
            phase  = '0;
            factor = FACTOR_W'(1);
            pending_outputs.delete();
        end else begin
            if (i_cfg_we)
                factor = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (pending_outputs.size() == 0) begin
                    log_mismatch("unexpected output item", int'($signed(i_out_data[15:0])), 0);
                end else begin
                    want = pending_outputs.pop_front();
                    if (i_out_data[15:0] !== want.re)
                        log_mismatch("out_re", int'($signed(i_out_data[15:0])),
                                     int'($signed(want.re)));
                    if (i_out_data[31:16] !== want.im)
                        log_mismatch("out_im", int'($signed(i_out_data[31:16])),
                                     int'($signed(want.im)));
                    if (i_out_clip !== want.clip)
                        log_mismatch("clipped", int'(i_out_clip), int'(want.clip));
                end
            end
            if (i_in_valid && i_in_ready)
                take_item(i_in_kind, i_in_data);
        end
        o_pending <= pending_outputs.size();
        o_errors  <= mismatches;
    end

endmodule

>>> verif/tb.sv
// Top-level testbench: clock, reset, stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
    import dcfir_pkg::*;

    localparam int          TAPS       = 64;
    localparam int          IDLE_LIMIT = 4000;
    localparam logic [15:0] Q_MAX      = 16'h7FFF;
    localparam logic [15:0] Q_MIN      = 16'h8000;
    localparam int          N_PHASES   = 11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    int          pending_count;
    int          error_count;
    int          idle_cycles = 0;
    logic [15:0] stall_clock = '0;

    int plan_factor [N_PHASES] = '{1, 0, 2, 3, 256, 511, 2, 5, 1, 4, 7};
    int plan_items  [N_PHASES] = '{250, 100, 120, 90, 300, 60, 60, 100, 150, 80, 70};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    decimating_complex_fir #(
        .TAPS(TAPS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    dcfir_checker #(
        .TAPS(TAPS)
    ) checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .i_in_ready (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .i_in_kind  (s_axis_tuser),
        .i_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_out_data (m_axis_tdata),
        .i_out_clip (m_axis_tuser),
        .o_pending  (pending_count),
        .o_errors   (error_count)
    );

    // output stalls: always ready, random, periodic, long holds
    always @(posedge i_clk) begin
        stall_clock <= stall_clock + 1'b1;
        case (stall_clock[9:8])
            2'd0: begin
                m_axis_tready <= 1'b1;
            end
            2'd1: begin
                m_axis_tready <= ($urandom_range(0, 9) < 6);
            end
            2'd2: begin
                m_axis_tready <= (stall_clock % 5 >= 2);
            end
            default: begin
                m_axis_tready <= (stall_clock[5:3] == 3'd0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[decimating_complex_fir] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [71:0] pack_fields(input logic [15:0] sre, input logic [15:0] sim,
                                                input logic [5:0] tidx, input logic [15:0] tre,
                                                input logic [15:0] tim);
        pack_fields = {2'b00, tim, tre, tidx, sim, sre};
    endfunction

    function automatic logic [15:0] rand_word();
        int unsigned pick;
        int          small_val;
        pick      = $urandom_range(0, 9);
        small_val = int'($urandom_range(0, 4095)) - 2048;
        if (pick < 6)
            rand_word = small_val[15:0];
        else if (pick < 9)
            rand_word = 16'($urandom());
        else
            rand_word = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    endfunction

    task automatic push_item(input logic kind, input logic [71:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic set_factor(input logic [8:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // wait for every predicted output, then let the datapath go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (TAPS + 10) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count, input bit bursty);
        int   left;
        int   gap;
        logic kind;
        left = 0;
        for (int n = 0; n < count; n++) begin
            if (bursty && left <= 0) begin
                left = $urandom_range(1, 24);
                gap  = $urandom_range(0, 8);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            left--;
            kind = ($urandom_range(0, 99) < 12) ? REQ_TAP : REQ_SAMPLE;
            push_item(kind, pack_fields(rand_word(), rand_word(), 6'($urandom_range(0, 63)),
                                        rand_word(), rand_word()));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_factor(9'd1);

        // extreme taps at both ends of the line and at index 21, then extreme samples
        push_item(REQ_TAP, pack_fields(16'h0, 16'h0, 6'd0, Q_MIN, Q_MIN));
        push_item(REQ_TAP, pack_fields(16'h0, 16'h0, 6'd63, Q_MAX, Q_MIN));
        push_item(REQ_TAP, pack_fields(Q_MAX, Q_MIN, 6'd21, Q_MAX, Q_MAX));
        push_item(REQ_SAMPLE, pack_fields(Q_MIN, Q_MIN, 6'd42, Q_MAX, Q_MIN));
        push_item(REQ_SAMPLE, pack_fields(Q_MAX, Q_MAX, 6'd0, 16'h0, 16'h0));
        push_item(REQ_SAMPLE, pack_fields(Q_MAX, Q_MIN, 6'd0, 16'h0, 16'h0));
        push_item(REQ_SAMPLE, pack_fields(Q_MIN, Q_MAX, 6'd0, 16'h0, 16'h0));
        push_item(REQ_SAMPLE, pack_fields(16'h0, 16'h0, 6'd0, 16'h0, 16'h0));
        // unit tap: half-LSB rounding in both directions
        push_item(REQ_TAP, pack_fields(16'h0, 16'h0, 6'd0, 16'h0001, 16'h0000));
        push_item(REQ_TAP, pack_fields(16'h0, 16'h0, 6'd21, 16'h0000, 16'h0000));
        push_item(REQ_TAP, pack_fields(16'h0, 16'h0, 6'd63, 16'h0000, 16'h0000));
        push_item(REQ_SAMPLE, pack_fields(16'h4000, 16'hC000, 6'd0, 16'h0, 16'h0));
        push_item(REQ_SAMPLE, pack_fields(16'h4001, 16'hBFFF, 6'd0, 16'h0, 16'h0));
        push_item(REQ_SAMPLE, pack_fields(16'hFFFF, 16'h0001, 6'd0, 16'h0, 16'h0));
        push_item(REQ_SAMPLE, pack_fields(Q_MAX, Q_MIN, 6'd0, 16'h0, 16'h0));
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            set_factor(plan_factor[p][8:0]);
            run_phase(plan_items[p], (p % 4) != 3);
            settle();
        end

        if (error_count == 0)
            $display("[decimating_complex_fir] OK");
        else
            $display("[decimating_complex_fir] ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/dcfir_pkg.sv
hw/rtl/dcfir_ram.sv
hw/rtl/dcfir_ctrl.sv
hw/rtl/dcfir_dp.sv
hw/rtl/decimating_complex_fir.sv
verif/dcfir_checker.sv
verif/tb.sv
